// ===== rtl/core/eulr_pkg.sv =====
package eulr_pkg;

  localparam int unsigned ANGLE_W         = 16;
  localparam int unsigned RES_W           = 16;
  localparam int unsigned ANGLE_FRAC_BITS = 6;
  localparam int unsigned COEFF_FRAC_BITS = 14;

  localparam int unsigned QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int unsigned HALF_Q  = 45 << ANGLE_FRAC_BITS;
  localparam int unsigned FULL    = 4 * QUARTER;
  localparam int unsigned R_W     = $clog2(FULL);
  localparam int unsigned F_W     = $clog2(HALF_Q + 1);

  localparam logic [46:0] DEG2RAD_Q52 = 47'd78602641689205;
  localparam int unsigned X_W    = 32;
  localparam int unsigned TRIG_W = 32;
  localparam int unsigned ACC_W  = 36;
  localparam int unsigned TERMS  = 7;

  localparam int unsigned LANE_LAT  = 5 + 2 * (TERMS - 1);
  localparam int unsigned MERGE_LAT = 3;
  localparam int unsigned LAT       = LANE_LAT + MERGE_LAT;

  localparam int unsigned OUT_SHIFT = 30 - COEFF_FRAC_BITS;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic signed [RES_W-1:0] r_row0_col0;
    logic signed [RES_W-1:0] r_row0_col1;
    logic signed [RES_W-1:0] r_row0_col2;
    logic signed [RES_W-1:0] r_row1_col0;
    logic signed [RES_W-1:0] r_row1_col1;
    logic signed [RES_W-1:0] r_row1_col2;
    logic signed [RES_W-1:0] r_row2_col0;
    logic signed [RES_W-1:0] r_row2_col1;
    logic signed [RES_W-1:0] r_row2_col2;
  } matrix_t;

  // Q30 x Q30 -> Q30, round half up
  function automatic logic signed [TRIG_W-1:0] mul30(input logic signed [TRIG_W-1:0] a,
                                                     input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b) + ((2*TRIG_W)'(1) <<< 29);
    return TRIG_W'(p >>> 30);
  endfunction

  // Q30 -> output format, round half up, saturate to +/-1.0
  function automatic logic [RES_W-1:0] to_out(input logic signed [TRIG_W+1:0] v);
    logic signed [TRIG_W+1:0] r;
    logic signed [TRIG_W+1:0] lim;
    lim = (TRIG_W+2)'(1) <<< COEFF_FRAC_BITS;
    r   = (v + ((TRIG_W+2)'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r[RES_W-1:0];
  endfunction

endpackage

// ===== rtl/core/eulr_sincos.sv =====
module eulr_sincos (
  input  logic                                 clk_i,
  input  logic signed [eulr_pkg::ANGLE_W-1:0]  angle_i,
  output logic signed [eulr_pkg::TRIG_W-1:0]   sin_o,
  output logic signed [eulr_pkg::TRIG_W-1:0]   cos_o
);
  import eulr_pkg::*;

  // reduction and fold
  logic signed [ANGLE_W+1:0] a_ext, r_d;
  logic [R_W-1:0]            r_q;
  quad_e                     q_d, q2_q;
  logic [R_W-1:0]            fr_d;
  logic [F_W-1:0]            f_d, f_q;
  logic                      k_d, k2_q, k3_q;
  quad_e                     q3_q;
  logic [F_W+46:0]           xp;
  logic [X_W-1:0]            x_q;
  logic [2*X_W:0]            xx;

  // series nodes and multiply stages
  logic [X_W:0]              nts_q [TERMS];
  logic [X_W:0]              ntc_q [TERMS];
  logic signed [ACC_W-1:0]   nsn_q [TERMS];
  logic signed [ACC_W-1:0]   ncs_q [TERMS];
  logic [X_W-1:0]            nx2_q [TERMS];
  quad_e                     nq_q  [TERMS];
  logic                      nk_q  [TERMS];

  logic [X_W-1:0]            mts_d [1:TERMS-1];
  logic [X_W-1:0]            mtc_d [1:TERMS-1];
  logic [X_W-1:0]            mts_q [1:TERMS-1];
  logic [X_W-1:0]            mtc_q [1:TERMS-1];
  logic signed [ACC_W-1:0]   msn_q [1:TERMS-1];
  logic signed [ACC_W-1:0]   mcs_q [1:TERMS-1];
  logic [X_W-1:0]            mx2_q [1:TERMS-1];
  quad_e                     mq_q  [1:TERMS-1];
  logic                      mk_q  [1:TERMS-1];

  logic [X_W-1:0]            dts_d [1:TERMS-1];
  logic [X_W-1:0]            dtc_d [1:TERMS-1];
  logic signed [ACC_W-1:0]   nsn_d [1:TERMS-1];
  logic signed [ACC_W-1:0]   ncs_d [1:TERMS-1];

  logic signed [ACC_W-1:0]   s0, c0, s1, c1;
  logic signed [TRIG_W-1:0]  sin_q, cos_q;

  always_comb begin
    a_ext = (ANGLE_W+2)'(angle_i);
    r_d   = a_ext;
    if (a_ext < 0) begin
      r_d = a_ext + (ANGLE_W+2)'(FULL);
      if (r_d < 0) begin
        r_d = r_d + (ANGLE_W+2)'(FULL);
      end
    end else if (a_ext >= (ANGLE_W+2)'(FULL)) begin
      r_d = a_ext - (ANGLE_W+2)'(FULL);
    end
  end

  always_comb begin
    if (r_q >= R_W'(3 * QUARTER)) begin
      q_d  = QUAD_3;
      fr_d = r_q - R_W'(3 * QUARTER);
    end else if (r_q >= R_W'(2 * QUARTER)) begin
      q_d  = QUAD_2;
      fr_d = r_q - R_W'(2 * QUARTER);
    end else if (r_q >= R_W'(QUARTER)) begin
      q_d  = QUAD_1;
      fr_d = r_q - R_W'(QUARTER);
    end else begin
      q_d  = QUAD_0;
      fr_d = r_q;
    end
    k_d = (fr_d > R_W'(HALF_Q));
    f_d = k_d ? F_W'(R_W'(QUARTER) - fr_d) : F_W'(fr_d);
  end

  assign xp = (F_W+47)'(f_q) * (F_W+47)'(DEG2RAD_Q52)
            + ((F_W+47)'(1) << (19 + ANGLE_FRAC_BITS));
  assign xx = (2*X_W+1)'(x_q) * (2*X_W+1)'(x_q) + ((2*X_W+1)'(1) << 31);

  for (genvar j = 1; j < TERMS; j++) begin : g_term
    localparam int unsigned DS = (2 * j) * (2 * j + 1);
    localparam int unsigned DC = (2 * j - 1) * (2 * j);
    localparam int unsigned PS = 32 + $clog2(DS);
    localparam int unsigned PC = 32 + $clog2(DC);
    localparam logic [33:0] MS = 34'(((64'd1 << PS) + 64'(DS) - 64'd1) / 64'(DS));
    localparam logic [33:0] MC = 34'(((64'd1 << PC) + 64'(DC) - 64'd1) / 64'(DC));

    logic [2*X_W+1:0] ps, pc;
    logic [66:0]      qs, qc;

    assign ps = (2*X_W+2)'(nts_q[j-1]) * (2*X_W+2)'(nx2_q[j-1]) + ((2*X_W+2)'(1) << 31);
    assign pc = (2*X_W+2)'(ntc_q[j-1]) * (2*X_W+2)'(nx2_q[j-1]) + ((2*X_W+2)'(1) << 31);
    assign mts_d[j] = ps[32 +: X_W];
    assign mtc_d[j] = pc[32 +: X_W];

    assign qs = (67'(mts_q[j]) + 67'(DS / 2)) * 67'(MS);
    assign qc = (67'(mtc_q[j]) + 67'(DC / 2)) * 67'(MC);
    assign dts_d[j] = X_W'(qs >> PS);
    assign dtc_d[j] = X_W'(qc >> PC);

    if (j % 2 == 1) begin : g_sub
      assign nsn_d[j] = msn_q[j] - $signed(ACC_W'(dts_d[j]));
      assign ncs_d[j] = mcs_q[j] - $signed(ACC_W'(dtc_d[j]));
    end else begin : g_add
      assign nsn_d[j] = msn_q[j] + $signed(ACC_W'(dts_d[j]));
      assign ncs_d[j] = mcs_q[j] + $signed(ACC_W'(dtc_d[j]));
    end
  end

  always_comb begin
    s0 = nk_q[TERMS-1] ? ncs_q[TERMS-1] : nsn_q[TERMS-1];
    c0 = nk_q[TERMS-1] ? nsn_q[TERMS-1] : ncs_q[TERMS-1];
    case (nq_q[TERMS-1])
      QUAD_1: begin
        s1 = c0;
        c1 = -s0;
      end
      QUAD_2: begin
        s1 = -s0;
        c1 = -c0;
      end
      QUAD_3: begin
        s1 = -c0;
        c1 = s0;
      end
      default: begin
        s1 = s0;
        c1 = c0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d[R_W-1:0];
    q2_q <= q_d;
    k2_q <= k_d;
    f_q  <= f_d;
    q3_q <= q2_q;
    k3_q <= k2_q;
    x_q  <= xp[20 + ANGLE_FRAC_BITS +: X_W];

    nts_q[0] <= (X_W+1)'(x_q);
    ntc_q[0] <= (X_W+1)'(1) << 32;
    nsn_q[0] <= $signed(ACC_W'(x_q));
    ncs_q[0] <= $signed(ACC_W'(1) << 32);
    nx2_q[0] <= xx[32 +: X_W];
    nq_q[0]  <= q3_q;
    nk_q[0]  <= k3_q;

    for (int j = 1; j < TERMS; j++) begin
      mts_q[j] <= mts_d[j];
      mtc_q[j] <= mtc_d[j];
      msn_q[j] <= nsn_q[j-1];
      mcs_q[j] <= ncs_q[j-1];
      mx2_q[j] <= nx2_q[j-1];
      mq_q[j]  <= nq_q[j-1];
      mk_q[j]  <= nk_q[j-1];

      nts_q[j] <= (X_W+1)'(dts_d[j]);
      ntc_q[j] <= (X_W+1)'(dtc_d[j]);
      nsn_q[j] <= nsn_d[j];
      ncs_q[j] <= ncs_d[j];
      nx2_q[j] <= mx2_q[j];
      nq_q[j]  <= mq_q[j];
      nk_q[j]  <= mk_q[j];
    end

    sin_q <= TRIG_W'((s1 + ACC_W'(2)) >>> 2);
    cos_q <= TRIG_W'((c1 + ACC_W'(2)) >>> 2);
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== rtl/core/eulr_merge.sv =====
module eulr_merge (
  input  logic                               clk_i,
  input  logic signed [eulr_pkg::TRIG_W-1:0] sx_i,
  input  logic signed [eulr_pkg::TRIG_W-1:0] cx_i,
  input  logic signed [eulr_pkg::TRIG_W-1:0] sy_i,
  input  logic signed [eulr_pkg::TRIG_W-1:0] cy_i,
  input  logic signed [eulr_pkg::TRIG_W-1:0] sz_i,
  input  logic signed [eulr_pkg::TRIG_W-1:0] cz_i,
  output eulr_pkg::matrix_t                  res_o
);
  import eulr_pkg::*;

  logic signed [TRIG_W-1:0] sxsy_q, cxsy_q, sy1_q, cz1_q, sz1_q;
  logic signed [TRIG_W-1:0] cycz_q, cysz_q, cxsz_q, cxcz_q, sxcy_q, sxsz_q, sxcz_q, cxcy_q;
  logic signed [TRIG_W-1:0] pa_q, pb_q, pc_q, pd_q, sy2_q;
  logic signed [TRIG_W-1:0] cycz2_q, cysz2_q, cxsz2_q, cxcz2_q;
  logic signed [TRIG_W-1:0] sxcy2_q, sxsz2_q, sxcz2_q, cxcy2_q;
  matrix_t                  res_q;

  function automatic logic signed [TRIG_W+1:0] ext(input logic signed [TRIG_W-1:0] v);
    return (TRIG_W+2)'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    sxsy_q <= mul30(sx_i, sy_i);
    cxsy_q <= mul30(cx_i, sy_i);
    cycz_q <= mul30(cy_i, cz_i);
    cysz_q <= mul30(cy_i, sz_i);
    cxsz_q <= mul30(cx_i, sz_i);
    cxcz_q <= mul30(cx_i, cz_i);
    sxcy_q <= mul30(sx_i, cy_i);
    sxsz_q <= mul30(sx_i, sz_i);
    sxcz_q <= mul30(sx_i, cz_i);
    cxcy_q <= mul30(cx_i, cy_i);
    sy1_q  <= sy_i;
    cz1_q  <= cz_i;
    sz1_q  <= sz_i;

    pa_q    <= mul30(sxsy_q, cz1_q);
    pb_q    <= mul30(sxsy_q, sz1_q);
    pc_q    <= mul30(cxsy_q, cz1_q);
    pd_q    <= mul30(cxsy_q, sz1_q);
    sy2_q   <= sy1_q;
    cycz2_q <= cycz_q;
    cysz2_q <= cysz_q;
    cxsz2_q <= cxsz_q;
    cxcz2_q <= cxcz_q;
    sxcy2_q <= sxcy_q;
    sxsz2_q <= sxsz_q;
    sxcz2_q <= sxcz_q;
    cxcy2_q <= cxcy_q;

    res_q.r_row0_col0 <= to_out(ext(cycz2_q));
    res_q.r_row0_col1 <= to_out(-ext(cysz2_q));
    res_q.r_row0_col2 <= to_out(ext(sy2_q));
    res_q.r_row1_col0 <= to_out(ext(cxsz2_q) + ext(pa_q));
    res_q.r_row1_col1 <= to_out(ext(cxcz2_q) - ext(pb_q));
    res_q.r_row1_col2 <= to_out(-ext(sxcy2_q));
    res_q.r_row2_col0 <= to_out(ext(sxsz2_q) - ext(pc_q));
    res_q.r_row2_col1 <= to_out(ext(sxcz2_q) + ext(pd_q));
    res_q.r_row2_col2 <= to_out(ext(cxcy2_q));
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/euler_xyz_rotation_matrix.sv =====
// The valid pipeline carries start alongside the sine/cosine lanes and the merge to done_o.
// Throughput: one angle word per cycle; busy is never raised.
// Per-axis sine/cosine lanes run a 7-term series, two stages per added term.
// Reset clears only the valid pipeline; datapath registers are not reset.
// Results are shown for one cycle on done_o; the receiver cannot stall.
module euler_xyz_rotation_matrix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  eulr_pkg::angles_t   in_i,
  output logic                done_o,
  output eulr_pkg::matrix_t   res_o
);
  import eulr_pkg::*;

  logic [LAT-1:0]           vld_q;
  logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start};
    end
  end

  eulr_sincos u_lane_x (
    .clk_i   (clk_i),
    .angle_i (in_i.angle_x),
    .sin_o   (sx),
    .cos_o   (cx)
  );

  eulr_sincos u_lane_y (
    .clk_i   (clk_i),
    .angle_i (in_i.angle_y),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  eulr_sincos u_lane_z (
    .clk_i   (clk_i),
    .angle_i (in_i.angle_z),
    .sin_o   (sz),
    .cos_o   (cz)
  );

  eulr_merge u_merge (
    .clk_i (clk_i),
    .sx_i  (sx),
    .cx_i  (cx),
    .sy_i  (sy),
    .cy_i  (cy),
    .sz_i  (sz),
    .cz_i  (cz),
    .res_o (res_o)
  );

  assign done_o = vld_q[LAT-1];

endmodule
